/* hdl/learning_switch_forwarder_defines.svh */
// assertion macros for the learning switch forwarder
// used by the top level only; no other dependencies
`ifndef LEARNING_SWITCH_FORWARDER_DEFINES_SVH
`define LEARNING_SWITCH_FORWARDER_DEFINES_SVH
`ifndef SYNTH
// clocked check, masked while reset is high
`define LSF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lsf assertion failed");
// clocked check that also holds during reset
`define LSF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lsf assertion failed");
`else
`define LSF_ASSERT(label, prop)
`define LSF_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* hdl/lsf_pkg.sv */
// shared types and constants of the learning switch forwarder
// no dependencies
`timescale 1ns / 1ps
package lsf_pkg;

  localparam int MAC_W     = 48;
  localparam int PORT_W    = 3;
  localparam int MASK_W    = 8;
  localparam int NUM_PORTS = 8;
  localparam int ENTRY_W   = MAC_W + PORT_W;

  // ports at or above NUM_PORTS never forward
  localparam logic [MASK_W-1:0] PORT_MASK =
    (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);

  localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

  localparam logic [1:0] ACT_DROP    = 2'd0;
  localparam logic [1:0] ACT_LOCAL   = 2'd1;
  localparam logic [1:0] ACT_UNICAST = 2'd2;
  localparam logic [1:0] ACT_FLOOD   = 2'd3;

  // register select is paddr[3]: 64-bit registers at 8 byte steps
  localparam logic REG_OWN_MAC   = 1'b0;
  localparam logic REG_FWD_PORTS = 1'b1;

  typedef struct packed {
    logic             start;
    logic [MAC_W-1:0] key;
  } scan_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              hit;
    logic [PORT_W-1:0] port;
  } scan_status_t;

endpackage

/* hdl/lsf_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module lsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/lsf_scan.sv */
// table scanner: walks entries below the fill count through the ram read
// port and compares each mac against the key; depends on lsf_pkg
`timescale 1ns / 1ps
module lsf_scan
  import lsf_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  scan_req_t                                                req,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]                         limit,
  output logic                                                     rd_en,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
  input  logic [ENTRY_W-1:0]                                       rd_data,
  output scan_status_t                                             status
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic              busy;
  logic              pend;
  logic [CW-1:0]     idx;
  logic              done;
  logic              hit;
  logic [PORT_W-1:0] port;
  logic              match;
  logic              issue;

  // pend marks that rd_data holds the entry read in the previous cycle
  assign match   = pend && (rd_data[MAC_W-1:0] == req.key);
  assign issue   = busy && !match && (idx != limit);
  assign rd_en   = issue;
  assign rd_addr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        pend <= 1'b0;
        idx  <= '0;
      end else if (busy) begin
        if (match) begin
          // first matching entry wins
          busy <= 1'b0;
          pend <= 1'b0;
          done <= 1'b1;
          hit  <= 1'b1;
          port <= rd_data[ENTRY_W-1:MAC_W];
        end else if (!pend && idx == limit) begin
          busy <= 1'b0;
          done <= 1'b1;
          hit  <= 1'b0;
        end else begin
          pend <= issue;
          if (issue) begin
            idx <= idx + CW'(1);
          end
        end
      end
    end
  end

  assign status = '{busy: busy, done: done, hit: hit, port: port};

endmodule

/* hdl/learning_switch_forwarder.sv */
// a request runs up to two sequential scans of the mac table (source, then destination),
// one entry per cycle through the single ram port
// a new request is taken only in the idle state; a finished result may wait
// in the output register while the next request is taken
// reset: synchronous, clears the fill count, control state and registers to
// own_mac 0 and forward_ports 0xff; no clearing pass over the table
`timescale 1ns / 1ps
`include "learning_switch_forwarder_defines.svh"
module learning_switch_forwarder
  import lsf_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  // apb configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // src_mac, dest_mac, ingress_port, zero fill
  input  logic         s_tuser,  // has_ingress
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,  // out_port, flood_mask, learn_dropped, zero fill
  output logic [1:0]   m_tuser   // action
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    IDLE,
    SRC_WAIT,
    LEARN,
    DST_CHECK,
    DST_WAIT,
    FINISH
  } state_t;

  state_t            state;
  logic [MAC_W-1:0]  own_mac;
  logic [MASK_W-1:0] forward_ports;
  logic [MAC_W-1:0]  src_mac;
  logic [MAC_W-1:0]  dest_mac;
  logic [PORT_W-1:0] ingress_port;
  logic              has_ingress;
  logic [CW-1:0]     entry_count;
  scan_req_t         scan_req;
  scan_status_t      scan_status;
  logic [1:0]        action;
  logic [PORT_W-1:0] out_port;
  logic [MASK_W-1:0] flood_mask;
  logic              learn_dropped;
  logic [MASK_W-1:0] fwd_eff;
  logic [MASK_W-1:0] ingress_bit;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac       <= '0;
      forward_ports <= {MASK_W{1'b1}};
    end else if (psel && penable && pwrite) begin
      case (paddr[3])
        REG_OWN_MAC:   own_mac       <= pwdata[MAC_W-1:0];
        REG_FWD_PORTS: forward_ports <= pwdata[MASK_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_OWN_MAC:   prdata = {{(64-MAC_W){1'b0}}, own_mac};
      REG_FWD_PORTS: prdata = {{(64-MASK_W){1'b0}}, forward_ports};
      default:       prdata = '0;
    endcase
  end

  // table storage and scanner
  assign wr_en = (state == LEARN);

  lsf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(entry_count[AW-1:0]),
    .wr_data({ingress_port, src_mac}),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lsf_scan #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .req    (scan_req),
    .limit  (entry_count),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .status (scan_status)
  );

  // sequencer
  assign s_tready    = (state == IDLE);
  assign fwd_eff     = forward_ports & PORT_MASK;
  assign ingress_bit = has_ingress ? (MASK_W'(1) << ingress_port) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      entry_count    <= '0;
      scan_req.start <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      scan_req.start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            src_mac       <= s_tdata[MAC_W-1:0];
            dest_mac      <= s_tdata[2*MAC_W-1:MAC_W];
            ingress_port  <= s_tdata[2*MAC_W+PORT_W-1:2*MAC_W];
            has_ingress   <= s_tuser;
            learn_dropped <= 1'b0;
            if (s_tuser) begin
              scan_req.start <= 1'b1;
              scan_req.key   <= s_tdata[MAC_W-1:0];
              state          <= SRC_WAIT;
            end else begin
              state <= DST_CHECK;
            end
          end
        end
        SRC_WAIT: begin
          if (scan_status.done) begin
            if (scan_status.hit) begin
              state <= DST_CHECK;
            end else if (entry_count == FULL_COUNT) begin
              learn_dropped <= 1'b1;
              state         <= DST_CHECK;
            end else begin
              state <= LEARN;
            end
          end
        end
        LEARN: begin
          entry_count <= entry_count + CW'(1);
          state       <= DST_CHECK;
        end
        DST_CHECK: begin
          if (dest_mac == own_mac || dest_mac == BCAST_MAC) begin
            action     <= ACT_LOCAL;
            out_port   <= '0;
            flood_mask <= '0;
            state      <= FINISH;
          end else begin
            // the scan sees a source learned by this same request
            scan_req.start <= 1'b1;
            scan_req.key   <= dest_mac;
            state          <= DST_WAIT;
          end
        end
        DST_WAIT: begin
          if (scan_status.done) begin
            flood_mask <= '0;
            out_port   <= '0;
            if (scan_status.hit) begin
              if (fwd_eff[scan_status.port]) begin
                action   <= ACT_UNICAST;
                out_port <= scan_status.port;
              end else begin
                action <= ACT_DROP;
              end
            end else begin
              action     <= ACT_FLOOD;
              flood_mask <= fwd_eff & ~ingress_bit;
            end
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, learn_dropped, flood_mask, out_port};
            m_tuser  <= action;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `LSF_ASSERT_ALWAYS(a_pready_high, pready)
  `LSF_ASSERT(a_count_bound, entry_count <= FULL_COUNT)
  `LSF_ASSERT(a_no_write_when_full, wr_en |-> entry_count != FULL_COUNT)
  `LSF_ASSERT(a_idle_not_scanning, s_tready |-> !scan_status.busy)
  `LSF_ASSERT(a_mask_only_flood, (m_tvalid && m_tuser != ACT_FLOOD) |-> m_tdata[10:3] == '0)

endmodule

/* dv/learning_switch_forwarder_test.sv */
// testbench for learning_switch_forwarder: drives frame headers and apb register writes,
// predicts each forwarding decision and compares it with the result stream
// depends on lsf_pkg and the learning_switch_forwarder rtl
`timescale 1ns / 1ps

import lsf_pkg::*;

localparam int TABLE_DEPTH = 64;
localparam int MAC_POOL_SIZE = 96;
localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 20;
localparam int MAX_PRINTED = 40;

typedef struct packed {
  logic [MAC_W-1:0]  src;
  logic [MAC_W-1:0]  dst;
  logic [PORT_W-1:0] ing;
  logic              has_ing;
} frame_header_t;

typedef struct packed {
  logic [1:0]        action;
  logic [PORT_W-1:0] out_port;
  logic [MASK_W-1:0] flood_mask;
  logic              learn_dropped;
} forward_decision_t;

class forwarding_scoreboard;
  logic [MAC_W-1:0]  own_mac;
  logic [MASK_W-1:0] fwd_ports;
  logic [MAC_W-1:0]  learned_mac[TABLE_DEPTH];
  logic [PORT_W-1:0] learned_port[TABLE_DEPTH];
  int                learned;
  forward_decision_t decisions_due[$];
  int                errors;
  int                checked;

  function new();
    own_mac = '0;
    fwd_ports = '1;
    learned = 0;
    errors = 0;
    checked = 0;
  endfunction

  function int lookup_mac(logic [MAC_W-1:0] mac);
    for (int i = 0; i < learned; i++) begin
      if (learned_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // learning happens first so the same header can hit its own source
  function forward_decision_t predict_decision(frame_header_t h);
    forward_decision_t d;
    logic [MASK_W-1:0] fwd;
    int hit;
    d = '0;
    d.action = ACT_DROP;
    fwd = fwd_ports & PORT_MASK;
    if (h.has_ing && lookup_mac(h.src) < 0) begin
      if (learned < TABLE_DEPTH) begin
        learned_mac[learned] = h.src;
        learned_port[learned] = h.ing;
        learned++;
      end else begin
        d.learn_dropped = 1'b1;
      end
    end
    if (h.dst == own_mac || h.dst == BCAST_MAC) begin
      d.action = ACT_LOCAL;
    end else begin
      hit = lookup_mac(h.dst);
      if (hit >= 0) begin
        if (fwd[learned_port[hit]]) begin
          d.action = ACT_UNICAST;
          d.out_port = learned_port[hit];
        end
      end else begin
        d.action = ACT_FLOOD;
        d.flood_mask = fwd;
        if (h.has_ing) d.flood_mask[h.ing] = 1'b0;
      end
    end
    return d;
  endfunction

  function void note_header(frame_header_t h);
    decisions_due.push_back(predict_decision(h));
  endfunction

  task report(string msg);
    if (errors < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_decision(forward_decision_t got);
    forward_decision_t want;
    checked++;
    if (decisions_due.size() == 0) begin
      report($sformatf("unexpected result action=%0d", got.action));
      return;
    end
    want = decisions_due.pop_front();
    if (got.action !== want.action)
      report($sformatf("action %0d, expected %0d", got.action, want.action));
    if (got.out_port !== want.out_port)
      report($sformatf("out_port %0d, expected %0d", got.out_port, want.out_port));
    if (got.flood_mask !== want.flood_mask)
      report($sformatf("flood_mask %02h, expected %02h", got.flood_mask, want.flood_mask));
    if (got.learn_dropped !== want.learn_dropped)
      report($sformatf("learn_dropped %0b, expected %0b", got.learn_dropped,
                       want.learn_dropped));
  endtask

  task wrap_up();
    if (decisions_due.size() != 0)
      report($sformatf("%0d results never arrived", decisions_due.size()));
  endtask
endclass

module learning_switch_forwarder_test;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;  // src_mac, dest_mac, ingress_port, zero fill
  logic         s_tuser = 1'b0;  // has_ingress
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;  // out_port, flood_mask, learn_dropped, zero fill
  logic [1:0]   m_tuser;  // action

  forwarding_scoreboard sb = new();
  logic [MAC_W-1:0] mac_pool[MAC_POOL_SIZE];
  bit calm = 1'b0;
  int sent = 0;

  learning_switch_forwarder #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #25_000_000;
    $display("learning_switch_forwarder_test: errors");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_header('{s_tdata[47:0], s_tdata[95:48], s_tdata[98:96], s_tuser});
      if (m_tvalid && m_tready)
        sb.check_decision('{m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[11]});
    end
  end

  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // valid is left high after acceptance so back-to-back requests need one assignment
  task automatic send_header(input frame_header_t h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, h.ing, h.dst, h.src};
    s_tuser <= h.has_ing;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.checked != sent) @(posedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_OWN_MAC) sb.own_mac = value[MAC_W-1:0];
    else sb.fwd_ports = value[MASK_W-1:0];
    @(posedge clk);
  endtask

  function automatic frame_header_t random_header();
    frame_header_t h;
    int r;
    r = $urandom_range(0, 99);
    h.src = (r < 85) ? mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)] : random_mac();
    r = $urandom_range(0, 99);
    if (r < 60) h.dst = mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
    else if (r < 70) h.dst = sb.own_mac;
    else if (r < 78) h.dst = BCAST_MAC;
    else h.dst = random_mac();
    h.ing = PORT_W'($urandom_range(0, 7));
    h.has_ing = ($urandom_range(0, 99) < 85);
    return h;
  endfunction

  initial begin
    logic [MAC_W-1:0] own;
    logic [MASK_W-1:0] fwd;
    for (int i = 0; i < MAC_POOL_SIZE; i++) mac_pool[i] = random_mac();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed headers under reset config: own mac zero, all ports forwarding
    send_header('{48'h0000_0000_00a1, 48'h0000_0000_0bb1, 3'd2, 1'b0});  // local origin
    send_header('{48'h0000_0000_00a1, 48'h0000_0000_0bb1, 3'd2, 1'b1});
    send_header('{48'h0000_0000_00b2, 48'h0000_0000_00a1, 3'd5, 1'b1});
    send_header('{48'h0000_0000_00c3, 48'h0000_0000_00c3, 3'd7, 1'b1});  // learn then hit
    send_header('{48'h0000_0000_00d4, 48'h0,              3'd0, 1'b1});  // own mac
    send_header('{48'h0000_0000_00e5, BCAST_MAC,          3'd6, 1'b1});
    send_header('{48'h0000_0000_00a1, 48'h0000_0000_00b2, 3'd4, 1'b1});  // known source
    send_header('{BCAST_MAC,          48'h5555_5555_5555, 3'd1, 1'b1});
    send_header('{48'h0,              48'haaaa_aaaa_aaaa, 3'd3, 1'b0});
    send_header('{48'h0,              48'h0000_0000_00d4, 3'd3, 1'b1});
    send_header('{48'h0000_0000_00f6, 48'h0000_0000_00b2, 3'd5, 1'b1});  // back to ingress
    send_header('{48'haaaa_aaaa_aaaa, 48'h0000_0000_00e5, 3'd7, 1'b1});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin own = random_mac(); fwd = 8'hff; end
        1: begin own = BCAST_MAC; fwd = 8'h00; end
        2: begin own = '0; fwd = MASK_W'($urandom_range(0, 255)); end
        3: begin own = mac_pool[3]; fwd = 8'h55; end
        4: begin own = random_mac(); fwd = 8'haa; end
        5: begin own = mac_pool[10]; fwd = MASK_W'($urandom_range(0, 255)); end
        6: begin own = random_mac(); fwd = 8'hff; end
        default: begin own = '0; fwd = 8'hfe; end
      endcase
      write_register(REG_OWN_MAC, {16'b0, own});
      write_register(REG_FWD_PORTS, {56'b0, fwd});
      calm = (ph == 6);
      repeat (240) send_header(random_header());
      drain();
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.wrap_up();
    if (sb.errors == 0) $display("learning_switch_forwarder_test: clean");
    else $display("learning_switch_forwarder_test: errors");
    $finish;
  end

endmodule
